// ===== hw/rtl/wfsc_pkg.sv =====
// Shared types and constants for the wall-following steering controller.
package wfsc_pkg;

  localparam int unsigned DIST_W  = 12;
  localparam int unsigned SPEED_W = 10;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned WAIT_W  = 8;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [DIST_W-1:0]  WALL_NEAR_MM  = 12'd200;
  localparam logic [DIST_W-1:0]  FRONT_NEAR_MM = 12'd150;
  localparam logic [DIST_W-1:0]  CLAMP_MM      = 12'd300;
  localparam logic [SPEED_W-1:0] MARCH_SPEED   = 10'd250;
  localparam logic [WAIT_W-1:0]  SETTLE_TICKS  = 8'd25;
  localparam logic [WAIT_W-1:0]  TURN_TICKS    = 8'd150;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LEFT  = 8'sd90;
  localparam logic signed [ANGLE_W-1:0] ANGLE_RIGHT = -8'sd90;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_KP_LEFT      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KI_LEFT      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KD_LEFT      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KP_RIGHT     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KI_RIGHT     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_KD_RIGHT     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_LEFT  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_RIGHT = 3'd7;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE     = 3'd0,
    MODE_FOLLOW_L = 3'd1,
    MODE_FOLLOW_R = 3'd2,
    MODE_TURN_L   = 3'd3,
    MODE_TURN_R   = 3'd4
  } mode_e;

  // per-loop pipeline control from the top level
  typedef struct packed {
    logic load_b;  // error stage takes a new item
    logic run_c;   // loop state updates with the item in the error stage
  } pid_ctrl_t;

endpackage

// ===== hw/rtl/wfsc_pid.sv =====
// One fixed-point PID loop: error/product stage plus integrator and last-error state.
module wfsc_pid (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wfsc_pkg::pid_ctrl_t     ctrl_i,
  input  logic [11:0]             front_i,
  input  logic [11:0]             rear_i,
  input  logic signed [15:0]      kp_i,
  input  logic signed [15:0]      ki_i,
  input  logic signed [15:0]      kd_i,
  input  logic signed [9:0]       target_i,
  output logic signed [15:0]      sum_o
);

  logic [11:0]        front_c, rear_c;
  logic signed [12:0] diff_c, err_wide;
  logic signed [10:0] err_d, err_q, last_q;
  logic signed [26:0] pe_d, pe_q, ie_d, ie_q;
  logic signed [11:0] derr;
  logic signed [27:0] de;
  logic signed [32:0] acc;
  logic signed [31:0] integ_d, integ_q;
  logic signed [33:0] total;
  logic signed [25:0] shifted;

  // error stage: clamp, difference, and the products that need no loop state
  always_comb begin
    front_c  = (front_i > wfsc_pkg::CLAMP_MM) ? wfsc_pkg::CLAMP_MM : front_i;
    rear_c   = (rear_i > wfsc_pkg::CLAMP_MM) ? wfsc_pkg::CLAMP_MM : rear_i;
    diff_c   = $signed({1'b0, front_c}) - $signed({1'b0, rear_c});
    err_wide = 13'(target_i) - diff_c;
    err_d    = err_wide[10:0];
    pe_d     = 27'(kp_i) * 27'(err_d);
    ie_d     = 27'(ki_i) * 27'(err_d);
  end

  // update stage: derivative product, saturating integrator, floored shift
  always_comb begin
    derr = 12'(err_q) - 12'(last_q);
    de   = 28'(kd_i) * 28'(derr);
    acc  = 33'(integ_q) + 33'(ie_q);
    if (acc[32] == acc[31]) begin
      integ_d = acc[31:0];
    end else if (acc[32]) begin
      integ_d = 32'sh8000_0000;
    end else begin
      integ_d = 32'sh7fff_ffff;
    end
    total   = 34'(pe_q) + 34'(integ_d) + 34'(de);
    shifted = total[33:8];
    if ((&shifted[25:15]) || !(|shifted[25:15])) begin
      sum_o = shifted[15:0];
    end else if (shifted[25]) begin
      sum_o = 16'sh8000;
    end else begin
      sum_o = 16'sh7fff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_b) begin
      err_q <= err_d;
      pe_q  <= pe_d;
      ie_q  <= ie_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
    end else if (ctrl_i.run_c) begin
      integ_q <= integ_d;
      last_q  <= err_q;
    end
  end

endmodule

// ===== hw/rtl/wall_follow_steering_controller.sv =====
// Top level of the wall-following steering controller.
//
//  channel  | dir | transfer when              | payload
//  s_axis   | in  | s_axis_tvalid_i & tready_o | six 12-bit distances
//  m_axis   | out | m_axis_tvalid_o & tready_i | speed, rate, angle, mode
//  cfg      | in  | cfg_we_i                   | gains and targets by index
//
// Three register stages: input, error/product, result. One item is taken every
// cycle while the output is not stalled, with the integrator and mode state
// closing their loop within the result stage.
// Stalls on the output ripple back stage by stage; reset clears state,
// configuration and all valid flags.
module wall_follow_steering_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // dist_front_left, dist_front_right, dist_rear_left, dist_rear_right,
  // dist_ahead_a, dist_ahead_b (12 bits each, from bit 0 up)
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // forward_speed[9:0], steer_rate[25:10], turn_angle[33:26], mode[36:34], zero pad
  output logic [39:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    PH_ENTRY = 2'd0,
    PH_RUN   = 2'd1,
    PH_END   = 2'd2
  } phase_e;

  // configuration
  logic signed [15:0] kp_l_q, ki_l_q, kd_l_q, kp_r_q, ki_r_q, kd_r_q;
  logic signed [9:0]  tgt_l_q, tgt_r_q;

  // pipeline control
  logic va_q, vb_q, vc_q;
  logic acc_a, adv_b, adv_c, a_free, b_free, c_free;

  // stage A / B payload
  logic [11:0] dist_q [6];
  logic [5:0]  near_d, near_q;

  // controller state
  wfsc_pkg::mode_e    mode_q, mode_d, want, mode_t;
  phase_e             phase_q, phase_d, phase_t;
  logic               hold_q, hold_d;
  logic [7:0]         wait_q, wait_d;
  logic [9:0]         speed_q, speed_d;
  logic signed [15:0] rate_q, rate_d;
  logic signed [7:0]  angle_q, angle_d;
  logic               pid_run;

  wfsc_pkg::pid_ctrl_t pid_ctrl;
  logic signed [15:0]  sum_l, sum_r;

  assign c_free = !vc_q || m_axis_tready_i;
  assign adv_c  = vb_q && c_free;
  assign b_free = !vb_q || adv_c;
  assign adv_b  = va_q && b_free;
  assign a_free = !va_q || adv_b;
  assign acc_a  = s_axis_tvalid_i && a_free;

  assign s_axis_tready_o = a_free;
  assign m_axis_tvalid_o = vc_q;
  assign m_axis_tdata_o  = {3'b000, mode_q, angle_q, rate_q, speed_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (acc_a) begin
        va_q <= 1'b1;
      end else if (adv_b) begin
        va_q <= 1'b0;
      end
      if (adv_b) begin
        vb_q <= 1'b1;
      end else if (adv_c) begin
        vb_q <= 1'b0;
      end
      if (adv_c) begin
        vc_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        vc_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_l_q  <= '0;
      ki_l_q  <= '0;
      kd_l_q  <= '0;
      kp_r_q  <= '0;
      ki_r_q  <= '0;
      kd_r_q  <= '0;
      tgt_l_q <= '0;
      tgt_r_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wfsc_pkg::REG_KP_LEFT:      kp_l_q  <= cfg_wdata_i;
        wfsc_pkg::REG_KI_LEFT:      ki_l_q  <= cfg_wdata_i;
        wfsc_pkg::REG_KD_LEFT:      kd_l_q  <= cfg_wdata_i;
        wfsc_pkg::REG_KP_RIGHT:     kp_r_q  <= cfg_wdata_i;
        wfsc_pkg::REG_KI_RIGHT:     ki_r_q  <= cfg_wdata_i;
        wfsc_pkg::REG_KD_RIGHT:     kd_r_q  <= cfg_wdata_i;
        wfsc_pkg::REG_TARGET_LEFT:  tgt_l_q <= cfg_wdata_i[9:0];
        wfsc_pkg::REG_TARGET_RIGHT: tgt_r_q <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_a) begin
      for (int i = 0; i < 6; i++) begin
        dist_q[i] <= s_axis_tdata_i[12*i +: 12];
      end
    end
    if (adv_b) begin
      near_q <= near_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      near_d[i] = dist_q[i] < wfsc_pkg::WALL_NEAR_MM;
    end
    for (int i = 4; i < 6; i++) begin
      near_d[i] = dist_q[i] < wfsc_pkg::FRONT_NEAR_MM;
    end
  end

  assign pid_ctrl.load_b = adv_b;
  assign pid_ctrl.run_c  = adv_c && pid_run;

  wfsc_pid u_pid_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (pid_ctrl),
    .front_i  (dist_q[0]),
    .rear_i   (dist_q[2]),
    .kp_i     (kp_l_q),
    .ki_i     (ki_l_q),
    .kd_i     (kd_l_q),
    .target_i (tgt_l_q),
    .sum_o    (sum_l)
  );

  wfsc_pid u_pid_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (pid_ctrl),
    .front_i  (dist_q[1]),
    .rear_i   (dist_q[3]),
    .kp_i     (kp_r_q),
    .ki_i     (ki_r_q),
    .kd_i     (kd_r_q),
    .target_i (tgt_r_q),
    .sum_o    (sum_r)
  );

  // mode choice and per-mode action for the item in the error stage
  always_comb begin
    if (near_q[4] || near_q[5]) begin
      want = (!near_q[0] && !near_q[2]) ? wfsc_pkg::MODE_TURN_L : wfsc_pkg::MODE_TURN_R;
    end else if (near_q[0] && near_q[2]) begin
      want = wfsc_pkg::MODE_FOLLOW_L;
    end else if (near_q[1] && near_q[3]) begin
      want = wfsc_pkg::MODE_FOLLOW_R;
    end else begin
      want = wfsc_pkg::MODE_IDLE;
    end

    if (want != mode_q && !hold_q) begin
      mode_t  = want;
      phase_t = PH_ENTRY;
    end else begin
      mode_t  = mode_q;
      phase_t = phase_q;
    end

    mode_d  = mode_t;
    phase_d = phase_t;
    hold_d  = hold_q;
    wait_d  = wait_q;
    speed_d = speed_q;
    rate_d  = rate_q;
    angle_d = angle_q;
    pid_run = 1'b0;

    unique case (mode_t)
      wfsc_pkg::MODE_FOLLOW_L, wfsc_pkg::MODE_FOLLOW_R: begin
        if (phase_t == PH_ENTRY) begin
          phase_d = PH_RUN;
        end else begin
          pid_run = 1'b1;
          speed_d = wfsc_pkg::MARCH_SPEED;
          rate_d  = (mode_t == wfsc_pkg::MODE_FOLLOW_L) ? sum_l : sum_r;
        end
      end
      wfsc_pkg::MODE_TURN_L, wfsc_pkg::MODE_TURN_R: begin
        if (phase_t == PH_ENTRY) begin
          speed_d = '0;
          rate_d  = '0;
          hold_d  = 1'b1;
          wait_d  = wfsc_pkg::SETTLE_TICKS;
          phase_d = PH_RUN;
        end else if (phase_t == PH_RUN) begin
          if (wait_q == '0) begin
            angle_d = (mode_t == wfsc_pkg::MODE_TURN_L) ? wfsc_pkg::ANGLE_LEFT
                                                        : wfsc_pkg::ANGLE_RIGHT;
            wait_d  = wfsc_pkg::TURN_TICKS;
            phase_d = PH_END;
          end else begin
            wait_d = wait_q - 8'd1;
          end
        end else begin
          // end phase; repeats harmlessly once the count has run out
          if (wait_q == '0) begin
            angle_d = '0;
            hold_d  = 1'b0;
          end else begin
            wait_d = wait_q - 8'd1;
          end
        end
      end
      default: begin
        speed_d = '0;
        rate_d  = '0;
        angle_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= wfsc_pkg::MODE_IDLE;
      phase_q <= PH_ENTRY;
      hold_q  <= 1'b0;
      wait_q  <= '0;
      speed_q <= '0;
      rate_q  <= '0;
      angle_q <= '0;
    end else if (adv_c) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      hold_q  <= hold_d;
      wait_q  <= wait_d;
      speed_q <= speed_d;
      rate_q  <= rate_d;
      angle_q <= angle_d;
    end
  end

endmodule

// ===== hw/rtl/wfsc_checker.sv =====
// Port-level checks for the steering controller, bound to the top level.
module wfsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  logic [9:0]  speed;
  logic [15:0] rate;
  logic [7:0]  angle;
  logic [2:0]  mode;
  logic        is_turn, is_follow;

  assign speed     = m_axis_tdata_o[9:0];
  assign rate      = m_axis_tdata_o[25:10];
  assign angle     = m_axis_tdata_o[33:26];
  assign mode      = m_axis_tdata_o[36:34];
  assign is_turn   = (mode == wfsc_pkg::MODE_TURN_L) || (mode == wfsc_pkg::MODE_TURN_R);
  assign is_follow = (mode == wfsc_pkg::MODE_FOLLOW_L) || (mode == wfsc_pkg::MODE_FOLLOW_R);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // downstream ready leaves no bubble at the input
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input blocked while output drains");

  a_angle_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (angle != 8'd0) |-> is_turn)
    else $error("turn angle outside a turn");

  a_speed_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (speed != 10'd0) |-> is_follow)
    else $error("forward speed outside wall following");

  a_turn_no_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && is_turn |-> (rate == 16'd0))
    else $error("steer rate during a turn");

endmodule

bind wall_follow_steering_controller wfsc_checker u_wfsc_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the wall-following steering controller: random and directed ticks.
module tb_top;
  import wfsc_pkg::*;

  localparam logic [1:0]  PH_ENTRY = 2'd0;
  localparam logic [1:0]  PH_RUN   = 2'd1;
  localparam logic [1:0]  PH_END   = 2'd2;
  localparam int          LOOP_LEFT  = 0;
  localparam int          LOOP_RIGHT = 1;
  localparam int          WALL_SENSORS = 4;
  localparam logic [5:0]  AHEAD_BITS = 6'b110000;
  localparam logic [5:0]  LEFT_BITS  = 6'b000101;
  localparam logic [5:0]  RIGHT_BITS = 6'b001010;
  localparam longint      ACC_MAX = 64'sd2147483647;
  localparam longint      ACC_MIN = -ACC_MAX - 1;
  localparam int          TARGET_MAX = 300;
  localparam int          PHASES = 7;
  localparam int          TICKS_PER_PHASE = 250;
  localparam int          RX_HOLD_CYCLES = 120;
  localparam int          QUIET_LIMIT = 2000;

  typedef enum int {GAINS_MODERATE, GAINS_MAX, GAINS_MIN, GAINS_WIDE, GAINS_ZERO} gain_set_e;
  typedef enum int {SCENE_LEFT, SCENE_RIGHT, SCENE_OPEN, SCENE_AHEAD, SCENE_NOISE} scene_e;

  typedef struct {
    logic [9:0]         speed;
    logic signed [15:0] rate;
    logic signed [7:0]  angle;
    mode_e              mode;
  } steer_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  wall_follow_steering_controller u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // controller state as the testbench sees it
  mode_e              cur_mode = MODE_IDLE;
  logic [1:0]         cur_phase = PH_ENTRY;
  logic               turn_hold = 1'b0;
  logic [7:0]         wait_cnt = '0;
  logic [9:0]         speed_cmd = '0;
  logic signed [15:0] rate_cmd = '0;
  logic signed [7:0]  angle_cmd = '0;
  int                 loop_last_err [2] = '{0, 0};
  longint             integral_acc [2] = '{0, 0};
  logic [15:0]        cfg_shadow [8] = '{default: '0};

  logic [71:0] dist_q [$];
  steer_cmd_t  steer_q [$];
  steer_cmd_t  want_cmd;
  int          n_queued = 0;
  int          n_accepted = 0;
  int          n_fail = 0;
  int          tx_gap = 0;
  int          rx_stall = 0;
  int          rx_hold = 0;
  int          hold_reqs = 0;
  int          holds_served = 0;
  int          quiet_cycles = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one PID loop: target minus clamped front-minus-rear difference, saturating integrator, Q8.8 sum
  function automatic logic signed [15:0] loop_update(input int k,
      input logic [11:0] front_mm, input logic [11:0] rear_mm,
      input logic [2:0] kp_idx, input logic [2:0] ki_idx,
      input logic [2:0] kd_idx, input logic [2:0] tgt_idx);
    longint kp, ki, kd, acc, s, q;
    int     f, r, err;
    kp = longint'($signed(cfg_shadow[kp_idx]));
    ki = longint'($signed(cfg_shadow[ki_idx]));
    kd = longint'($signed(cfg_shadow[kd_idx]));
    f = front_mm;
    r = rear_mm;
    if (f > CLAMP_MM) f = CLAMP_MM;
    if (r > CLAMP_MM) r = CLAMP_MM;
    err = int'($signed(cfg_shadow[tgt_idx][9:0])) - (f - r);
    acc = integral_acc[k] + ki * err;
    if (acc > ACC_MAX) acc = ACC_MAX;
    if (acc < ACC_MIN) acc = ACC_MIN;
    integral_acc[k] = acc;
    s = kp * err + acc + kd * (err - loop_last_err[k]);
    loop_last_err[k] = err;
    q = s >>> 8;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic steer_cmd_t compute_steering(input logic [71:0] dists);
    logic [5:0]         near;
    logic [11:0]        d;
    mode_e              wanted;
    logic signed [15:0] left_sum, right_sum;
    steer_cmd_t         cmd;
    int                 i;
    for (i = 0; i < 6; i++) begin
      d = dists[i*12 +: 12];
      near[i] = d < ((i < WALL_SENSORS) ? WALL_NEAR_MM : FRONT_NEAR_MM);
    end
    if ((near & AHEAD_BITS) != '0)
      wanted = ((near & LEFT_BITS) == '0) ? MODE_TURN_L : MODE_TURN_R;
    else if ((near & LEFT_BITS) == LEFT_BITS)
      wanted = MODE_FOLLOW_L;
    else if ((near & RIGHT_BITS) == RIGHT_BITS)
      wanted = MODE_FOLLOW_R;
    else
      wanted = MODE_IDLE;

    // a turn in progress pins the mode
    if (wanted != cur_mode && !turn_hold) begin
      cur_mode = wanted;
      cur_phase = PH_ENTRY;
    end

    case (cur_mode)
      MODE_FOLLOW_L, MODE_FOLLOW_R: begin
        if (cur_phase == PH_ENTRY) begin
          cur_phase = PH_RUN;
        end else begin
          left_sum = loop_update(LOOP_LEFT, dists[11:0], dists[35:24],
                                 REG_KP_LEFT, REG_KI_LEFT, REG_KD_LEFT, REG_TARGET_LEFT);
          right_sum = loop_update(LOOP_RIGHT, dists[23:12], dists[47:36],
                                  REG_KP_RIGHT, REG_KI_RIGHT, REG_KD_RIGHT, REG_TARGET_RIGHT);
          speed_cmd = MARCH_SPEED;
          rate_cmd = (cur_mode == MODE_FOLLOW_L) ? left_sum : right_sum;
        end
      end
      MODE_TURN_L, MODE_TURN_R: begin
        if (cur_phase == PH_ENTRY) begin
          speed_cmd = '0;
          rate_cmd = '0;
          turn_hold = 1'b1;
          wait_cnt = SETTLE_TICKS;
          cur_phase = PH_RUN;
        end else if (cur_phase == PH_RUN) begin
          if (wait_cnt == '0) begin
            angle_cmd = (cur_mode == MODE_TURN_L) ? ANGLE_LEFT : ANGLE_RIGHT;
            wait_cnt = TURN_TICKS;
            cur_phase = PH_END;
          end else begin
            wait_cnt--;
          end
        end else begin
          if (wait_cnt == '0) begin
            angle_cmd = '0;
            turn_hold = 1'b0;
          end else begin
            wait_cnt--;
          end
        end
      end
      default: begin
        speed_cmd = '0;
        rate_cmd = '0;
        angle_cmd = '0;
      end
    endcase

    cmd.speed = speed_cmd;
    cmd.rate = rate_cmd;
    cmd.angle = angle_cmd;
    cmd.mode = cur_mode;
    return cmd;
  endfunction

  // sensor sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
      tx_gap = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        steer_q.push_back(compute_steering(s_axis_tdata_i));
        n_accepted++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (dist_q.size() > 0) begin
          s_axis_tdata_i <= dist_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          if (tx_gaps_on) tx_gap = draw_gap();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // command receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      rx_stall = 0;
      rx_hold = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (steer_q.size() == 0) begin
          $error("steering command with none outstanding: %h", m_axis_tdata_o);
          n_fail++;
        end else begin
          want_cmd = steer_q.pop_front();
          if (m_axis_tdata_o[9:0] !== want_cmd.speed) begin
            $error("forward_speed: expected %0d, got %0d", want_cmd.speed, m_axis_tdata_o[9:0]);
            n_fail++;
          end
          if (m_axis_tdata_o[25:10] !== want_cmd.rate) begin
            $error("steer_rate: expected %0d, got %0d", want_cmd.rate,
                   $signed(m_axis_tdata_o[25:10]));
            n_fail++;
          end
          if (m_axis_tdata_o[33:26] !== want_cmd.angle) begin
            $error("turn_angle: expected %0d, got %0d", want_cmd.angle,
                   $signed(m_axis_tdata_o[33:26]));
            n_fail++;
          end
          if (m_axis_tdata_o[36:34] !== want_cmd.mode) begin
            $error("mode: expected %0d, got %0d", want_cmd.mode, m_axis_tdata_o[36:34]);
            n_fail++;
          end
        end
      end
      if (rx_hold == 0 && holds_served != hold_reqs) begin
        holds_served++;
        rx_hold = RX_HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (rx_gaps_on) rx_stall = draw_gap();
      end
    end
  end

  // watchdog: too long without any transfer or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [11:0] near_mm(input logic [11:0] thr);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return thr - 12'd1;
    return 12'($urandom_range(0, thr - 12'd1));
  endfunction

  function automatic logic [11:0] far_mm(input logic [11:0] thr);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return thr;
    if (r == 1) return 12'hFFF;
    // plenty of values around the clamp limit
    if (r < 5) return 12'($urandom_range(thr, 32'(CLAMP_MM) + 40));
    return 12'($urandom_range(thr, 4095));
  endfunction

  function automatic logic [11:0] any_mm(input logic [11:0] thr);
    return ($urandom_range(0, 1) != 0) ? near_mm(thr) : far_mm(thr);
  endfunction

  task automatic queue_tick(input logic [11:0] fl, input logic [11:0] fr,
                            input logic [11:0] rl, input logic [11:0] rr,
                            input logic [11:0] aa, input logic [11:0] ab);
    dist_q.push_back({ab, aa, rr, rl, fr, fl});
    n_queued++;
  endtask

  task automatic queue_scene(input scene_e sc);
    logic [11:0] aa, ab;
    case (sc)
      SCENE_LEFT:
        queue_tick(near_mm(WALL_NEAR_MM), any_mm(WALL_NEAR_MM), near_mm(WALL_NEAR_MM),
                   any_mm(WALL_NEAR_MM), far_mm(FRONT_NEAR_MM), far_mm(FRONT_NEAR_MM));
      SCENE_RIGHT:
        queue_tick(any_mm(WALL_NEAR_MM), near_mm(WALL_NEAR_MM), far_mm(WALL_NEAR_MM),
                   near_mm(WALL_NEAR_MM), far_mm(FRONT_NEAR_MM), far_mm(FRONT_NEAR_MM));
      SCENE_OPEN:
        queue_tick(any_mm(WALL_NEAR_MM), any_mm(WALL_NEAR_MM), far_mm(WALL_NEAR_MM),
                   far_mm(WALL_NEAR_MM), far_mm(FRONT_NEAR_MM), far_mm(FRONT_NEAR_MM));
      SCENE_AHEAD: begin
        aa = any_mm(FRONT_NEAR_MM);
        ab = any_mm(FRONT_NEAR_MM);
        if ($urandom_range(0, 1) != 0) aa = near_mm(FRONT_NEAR_MM);
        else ab = near_mm(FRONT_NEAR_MM);
        queue_tick(any_mm(WALL_NEAR_MM), any_mm(WALL_NEAR_MM), any_mm(WALL_NEAR_MM),
                   any_mm(WALL_NEAR_MM), aa, ab);
      end
      default:
        queue_tick(12'($urandom()), 12'($urandom()), 12'($urandom()),
                   12'($urandom()), 12'($urandom()), 12'($urandom()));
    endcase
  endtask

  task automatic apply_settings(input gain_set_e set);
    int          r;
    logic        is_tgt;
    logic [15:0] v;
    for (r = REG_KP_LEFT; r <= REG_TARGET_RIGHT; r++) begin
      is_tgt = (r >= REG_TARGET_LEFT);
      case (set)
        GAINS_MAX:  v = is_tgt ? 16'(TARGET_MAX) : 16'h7FFF;
        GAINS_MIN:  v = is_tgt ? 16'(-TARGET_MAX) : 16'h8000;
        GAINS_ZERO: v = '0;
        GAINS_MODERATE:
          v = is_tgt ? 16'($urandom_range(0, 600) - 300) : 16'($urandom_range(0, 1024) - 512);
        default:
          v = is_tgt ? 16'($urandom_range(0, 600) - 300) : 16'($urandom());
      endcase
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= r[2:0];
      cfg_wdata_i <= v;
      cfg_shadow[r] = is_tgt ? {6'b0, v[9:0]} : v;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    gain_set_e phase_gains [PHASES];
    scene_e    sc;
    int        ph, n, len, r;
    phase_gains = '{GAINS_MODERATE, GAINS_MAX, GAINS_MIN, GAINS_WIDE,
                    GAINS_ZERO, GAINS_WIDE, GAINS_MODERATE};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (ph = 0; ph < PHASES; ph++) begin
      apply_settings(phase_gains[ph]);
      @(negedge clk_i);
      tx_gaps_on = (ph != 2);
      rx_gaps_on = (ph != 2);

      if (ph == 0) begin
        queue_tick(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        queue_tick(12'd0, 12'd0, 12'd0, 12'd0, 12'hFFF, 12'hFFF);       // follow left, entry
        queue_tick(12'd0, 12'd0, 12'd199, 12'd199, 12'hFFF, 12'hFFF);
        queue_tick(12'd199, 12'hFFF, 12'd0, 12'hFFF, 12'd150, 12'd150);
        queue_tick(12'hFFF, 12'd0, 12'd200, 12'd199, 12'hFFF, 12'hFFF); // over to right wall
        queue_tick(12'd301, 12'd199, 12'd300, 12'd0, 12'hFFF, 12'hFFF);
        queue_tick(12'd300, 12'd150, 12'hFFF, 12'd150, 12'd2048, 12'd2048);
        queue_tick(12'd200, 12'd200, 12'd200, 12'd200, 12'd150, 12'd150); // thresholds, idle
        queue_tick(12'd199, 12'd199, 12'd199, 12'd199, 12'd151, 12'hFFF); // both walls
        queue_tick(12'd0, 12'hFFF, 12'd199, 12'hFFF, 12'hFFF, 12'hFFF);
        queue_tick(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
        queue_tick(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA);
        queue_tick(12'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'd149); // obstacle, turn right
        queue_tick(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'd149, 12'hFFF); // ignored while held
        queue_tick(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
      end

      n = 0;
      while (n < TICKS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 35) sc = SCENE_LEFT;
        else if (r < 70) sc = SCENE_RIGHT;
        else if (r < 85) sc = SCENE_OPEN;
        else if (r < 88) sc = SCENE_AHEAD;
        else sc = SCENE_NOISE;
        len = (sc == SCENE_AHEAD || sc == SCENE_NOISE) ? $urandom_range(1, 4)
                                                         : $urandom_range(1, 30);
        repeat (len) queue_scene(sc);
        n += len;
      end

      // receiver backs off while the sender keeps offering
      if (ph == 1 || ph == 4) hold_reqs++;

      while (n_accepted != n_queued || steer_q.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end

    repeat (8) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== wall_follow_steering_controller.f =====
hw/rtl/wfsc_pkg.sv
hw/rtl/wfsc_pid.sv
hw/rtl/wall_follow_steering_controller.sv
hw/rtl/wfsc_checker.sv
verif/tb_top.sv
